[src/snp_pkg.sv]
// Shared types and constants for the register name parser.
// Character codes, grammar phase codes, kind codes, parse state and result types.
// No dependencies.
package snp_pkg;

  // Characters of the grammar
  localparam logic [7:0] CH_W     = 8'h77;  // 'w'
  localparam logic [7:0] CH_S     = 8'h73;  // 's'
  localparam logic [7:0] CH_D     = 8'h64;  // 'd'
  localparam logic [7:0] CH_V     = 8'h76;  // 'v'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_FOUR  = 8'h34;  // '4'
  localparam logic [7:0] CH_TWO   = 8'h32;  // '2'
  localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
  localparam logic [7:0] CH_OPEN  = 8'h5B;  // '['
  localparam logic [7:0] CH_CLOSE = 8'h5D;  // ']'

  // Grammar phases
  localparam logic [3:0] PH_START     = 4'd0;
  localparam logic [3:0] PH_FIRST_NUM = 4'd1;
  localparam logic [3:0] PH_NUM       = 4'd2;
  localparam logic [3:0] PH_VNUM      = 4'd3;
  localparam logic [3:0] PH_ARR       = 4'd4;
  localparam logic [3:0] PH_ARR_S     = 4'd5;
  localparam logic [3:0] PH_ARR_D     = 4'd6;
  localparam logic [3:0] PH_OPEN      = 4'd7;
  localparam logic [3:0] PH_LANE1     = 4'd8;
  localparam logic [3:0] PH_LANE      = 4'd9;
  localparam logic [3:0] PH_DONE      = 4'd10;

  // Kind codes (prefix uses the same codes, with KIND_V for 'v')
  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_W    = 3'd1;
  localparam logic [2:0] KIND_S    = 3'd2;
  localparam logic [2:0] KIND_D    = 3'd3;
  localparam logic [2:0] KIND_V4S  = 3'd4;
  localparam logic [2:0] KIND_V2D  = 3'd5;
  localparam logic [2:0] KIND_V    = 3'd4;

  // Range limits
  localparam logic [5:0] W_MAX      = 6'd30;
  localparam logic [5:0] REG_MAX    = 6'd31;
  localparam logic [5:0] LANE4S_MAX = 6'd3;
  localparam logic [5:0] LANE2D_MAX = 6'd1;
  localparam logic [5:0] ACC_SAT    = 6'd63;

  localparam int TDATA_IN_W  = 8;
  localparam int TDATA_OUT_W = 16;

  typedef struct packed {
    logic [3:0] phase;
    logic [2:0] prefix;
    logic [5:0] num;
    logic [5:0] lane;
    logic       wide;
    logic       err;
  } parse_state_t;

  typedef struct packed {
    logic [2:0] kind_code;
    logic [4:0] reg_number;
    logic [1:0] lane_number;
  } parse_result_t;

  localparam parse_state_t STATE_CLEAR = '{
    phase: PH_START, prefix: KIND_NONE, num: 6'd0, lane: 6'd0, wide: 1'b0, err: 1'b0
  };

  // Decimal digit test
  function automatic logic is_dec_char(input logic [7:0] c);
    is_dec_char = (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // acc*10 + digit, saturating at 63
  function automatic logic [5:0] acc_digit(input logic [5:0] acc, input logic [7:0] c);
    logic [9:0] v;
    logic [7:0] d;
    d = c - CH_ZERO;
    v = {4'd0, acc} * 10'd10 + {6'd0, d[3:0]};
    acc_digit = (v > {4'd0, ACC_SAT}) ? ACC_SAT : v[5:0];
  endfunction

endpackage

[src/snp_step.sv]
// One parse step: next grammar state and the result for one character.
// Pure combinational logic; the caller registers state and result.
// Depends on snp_pkg.
module snp_step (
  input  snp_pkg::parse_state_t  cur,
  input  logic [7:0]             char_code,
  input  logic                   last_char,
  output snp_pkg::parse_state_t  nxt,
  output snp_pkg::parse_result_t res
);
  import snp_pkg::*;

  parse_state_t upd;
  logic         dig;

  assign dig = is_dec_char(char_code);

  // Grammar transition for one character
  always_comb begin
    upd = cur;
    if (!cur.err) begin
      unique case (cur.phase)
        PH_START: begin
          upd.phase = PH_FIRST_NUM;
          if (char_code == CH_W)      upd.prefix = KIND_W;
          else if (char_code == CH_S) upd.prefix = KIND_S;
          else if (char_code == CH_D) upd.prefix = KIND_D;
          else if (char_code == CH_V) upd.prefix = KIND_V;
          else begin
            upd.err   = 1'b1;
            upd.phase = cur.phase;
          end
        end
        PH_FIRST_NUM: begin
          if (!dig) upd.err = 1'b1;
          else begin
            upd.num   = acc_digit(cur.num, char_code);
            upd.phase = (cur.prefix == KIND_V) ? PH_VNUM : PH_NUM;
          end
        end
        PH_NUM: begin
          if (!dig) upd.err = 1'b1;
          else      upd.num = acc_digit(cur.num, char_code);
        end
        PH_VNUM: begin
          if (dig)                     upd.num   = acc_digit(cur.num, char_code);
          else if (char_code == CH_DOT) upd.phase = PH_ARR;
          else                         upd.err   = 1'b1;
        end
        PH_ARR: begin
          if (char_code == CH_FOUR)     upd.phase = PH_ARR_S;
          else if (char_code == CH_TWO) upd.phase = PH_ARR_D;
          else                          upd.err   = 1'b1;
        end
        PH_ARR_S: begin
          if (char_code == CH_S) begin
            upd.wide  = 1'b0;
            upd.phase = PH_OPEN;
          end else upd.err = 1'b1;
        end
        PH_ARR_D: begin
          if (char_code == CH_D) begin
            upd.wide  = 1'b1;
            upd.phase = PH_OPEN;
          end else upd.err = 1'b1;
        end
        PH_OPEN: begin
          if (char_code == CH_OPEN) upd.phase = PH_LANE1;
          else                      upd.err   = 1'b1;
        end
        PH_LANE1: begin
          if (!dig) upd.err = 1'b1;
          else begin
            upd.lane  = acc_digit(cur.lane, char_code);
            upd.phase = PH_LANE;
          end
        end
        PH_LANE: begin
          if (dig)                        upd.lane  = acc_digit(cur.lane, char_code);
          else if (char_code == CH_CLOSE) upd.phase = PH_DONE;
          else                            upd.err   = 1'b1;
        end
        PH_DONE: begin
          // trailing characters ignored
        end
        default: upd.err = 1'b1;
      endcase
    end
  end

  // Result from the updated state; meaningful only on the last character
  always_comb begin
    res = '{kind_code: KIND_NONE, reg_number: 5'd0, lane_number: 2'd0};
    if (!upd.err) begin
      if (upd.phase == PH_NUM) begin
        if (upd.prefix == KIND_W && upd.num <= W_MAX) begin
          res.kind_code  = KIND_W;
          res.reg_number = upd.num[4:0];
        end else if ((upd.prefix == KIND_S || upd.prefix == KIND_D) && upd.num <= REG_MAX) begin
          res.kind_code  = upd.prefix;
          res.reg_number = upd.num[4:0];
        end
      end else if (upd.phase == PH_DONE && upd.num <= REG_MAX) begin
        if (!upd.wide && upd.lane <= LANE4S_MAX) begin
          res.kind_code   = KIND_V4S;
          res.reg_number  = upd.num[4:0];
          res.lane_number = upd.lane[1:0];
        end else if (upd.wide && upd.lane <= LANE2D_MAX) begin
          res.kind_code   = KIND_V2D;
          res.reg_number  = upd.num[4:0];
          res.lane_number = upd.lane[1:0];
        end
      end
    end
  end

  // A name restarts after its last character
  assign nxt = last_char ? STATE_CLEAR : upd;

endmodule

[src/subregister_name_parser_top.sv]
// Register name parser: input register, parse step, result register.
// An item is registered at the input, then parsed; its result is held in
// the result register. A last character waits while a result is stalled.
// Throughput: one character per cycle, set by the single-step parse logic.
// Reset (rst, synchronous, active high) empties both stages and returns
// the parser to the start of a name.
module subregister_name_parser_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [snp_pkg::TDATA_IN_W-1:0]   s_axis_tdata,   // [7:0] char_code
  input  logic                             s_axis_tlast,   // last_char
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [snp_pkg::TDATA_OUT_W-1:0]  m_axis_tdata    // [2:0] kind_code,
                                                           // [7:3] reg_number,
                                                           // [9:8] lane_number
);
  import snp_pkg::*;

  logic          in_valid;
  logic [7:0]    in_char;
  logic          in_last;
  logic          fire;
  logic          out_free;
  parse_state_t  state;
  parse_state_t  state_next;
  parse_result_t step_res;
  parse_result_t out_res;

  // A non-last character never needs the result slot
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign fire          = in_valid && (!in_last || out_free);
  assign s_axis_tready = !in_valid || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char <= s_axis_tdata[7:0];
      in_last <= s_axis_tlast;
    end
  end

  snp_step u_step (
    .cur       (state),
    .char_code (in_char),
    .last_char (in_last),
    .nxt       (state_next),
    .res       (step_res)
  );

  // Parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_CLEAR;
    end else if (fire) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire && in_last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_last) begin
      out_res <= step_res;
    end
  end

  assign m_axis_tdata = {{(TDATA_OUT_W - 10){1'b0}}, out_res.lane_number,
                         out_res.reg_number, out_res.kind_code};

endmodule

[src/snp_checker.sv]
// Port-level checks for the register name parser.
// Attached to subregister_name_parser_top by the bind at the end of this file.
// Depends on snp_pkg.
module snp_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [snp_pkg::TDATA_OUT_W-1:0]  m_axis_tdata
);
  import snp_pkg::*;

  logic [2:0] kind;
  logic [4:0] regn;
  logic [1:0] lane;

  assign kind = m_axis_tdata[2:0];
  assign regn = m_axis_tdata[7:3];
  assign lane = m_axis_tdata[9:8];

  // Invalid names report zero register and lane
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && kind == KIND_NONE |-> regn == 5'd0 && lane == 2'd0)
    else $error("invalid result with nonzero register or lane");

  // Lane only for vector kinds, and within the form's range
  a_lane_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && lane != 2'd0 |->
      kind == KIND_V4S || (kind == KIND_V2D && lane == 2'd1))
    else $error("lane out of range for kind");

  // w31 does not exist
  a_w_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && kind == KIND_W |-> regn != 5'd31)
    else $error("w register out of range");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

bind subregister_name_parser_top snp_checker u_snp_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[tb/sv/tb_top.sv]
// Self-checking bench for subregister_name_parser_top: register names go in one character
// per item, and each verdict on a last character is compared with an in-bench parser.
// Depends on snp_pkg and on the RTL top only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import snp_pkg::*;

  localparam int RANDOM_ITEMS = 1000;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 3000;

  typedef struct {
    string         text;   // used when raw < 0
    int            raw;    // single byte name
    bit            known;  // verdict typed in below
    parse_result_t want;
  } name_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;

  // Bench copy of the parse state
  logic [3:0] pr_phase  = PH_START;
  logic [2:0] pr_prefix = KIND_NONE;
  logic [5:0] pr_num    = '0;
  logic [5:0] pr_lane   = '0;
  logic       pr_wide   = 1'b0;
  logic       pr_err    = 1'b0;

  parse_result_t pending_verdicts[$];
  logic [7:0]    name_chars[$];
  int            mismatches = 0;
  int            chars_sent = 0;
  int            idle_cycles = 0;
  bit            quiet = 1'b0;       // no gaps on either side
  bit            stall_hold = 1'b0;  // receiver holds off for a long stretch

  // Directed names: form extremes, leading zeros, overflow, junk after the
  // bracket, incomplete names, bad characters and byte extremes
  name_row_t name_rows[12] = '{
    '{"w30",        -1, 1'b1, '{KIND_W,    5'd30, 2'd0}},
    '{"w31",        -1, 1'b1, '{KIND_NONE, 5'd0,  2'd0}},
    '{"s0",         -1, 1'b1, '{KIND_S,    5'd0,  2'd0}},
    '{"d031",       -1, 1'b1, '{KIND_D,    5'd31, 2'd0}},
    '{"s999",       -1, 1'b1, '{KIND_NONE, 5'd0,  2'd0}},
    '{"v31.4s[3]",  -1, 1'b1, '{KIND_V4S,  5'd31, 2'd3}},
    '{"v0.2d[2]",   -1, 1'b1, '{KIND_NONE, 5'd0,  2'd0}},
    '{"v1.2d[1]]x", -1, 1'b0, '{KIND_NONE, 5'd0,  2'd0}},
    '{"v3.4s[",     -1, 1'b1, '{KIND_NONE, 5'd0,  2'd0}},
    '{"q",          -1, 1'b1, '{KIND_NONE, 5'd0,  2'd0}},
    '{"",          255, 1'b1, '{KIND_NONE, 5'd0,  2'd0}},
    '{"",            0, 1'b1, '{KIND_NONE, 5'd0,  2'd0}}
  };

  subregister_name_parser_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] char_code
    .s_axis_tlast  (s_axis_tlast),   // last_char
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // [2:0] kind_code, [7:3] reg_number, [9:8] lane_number
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Decimal accumulate, pinned at 63 so overflow stays out of range
  function automatic logic [5:0] dec_accum(input logic [5:0] acc, input logic [7:0] c);
    int v;
    v = int'(acc) * 10 + int'(c) - int'(CH_ZERO);
    return (v > 63) ? 6'd63 : 6'(v);
  endfunction

  // Advance the bench parser by one character; returns 1 with the verdict
  // on a last character and then clears the name
  function automatic bit predict_name_char(input logic [7:0] c, input logic last,
                                           output parse_result_t verdict);
    bit dig;
    dig = (c >= CH_ZERO) && (c <= CH_NINE);
    verdict = '{KIND_NONE, 5'd0, 2'd0};
    if (!pr_err) begin
      case (pr_phase)
        PH_START: begin
          pr_phase = PH_FIRST_NUM;
          if (c == CH_W) pr_prefix = KIND_W;
          else if (c == CH_S) pr_prefix = KIND_S;
          else if (c == CH_D) pr_prefix = KIND_D;
          else if (c == CH_V) pr_prefix = KIND_V;
          else begin
            pr_phase = PH_START;
            pr_err = 1'b1;
          end
        end
        PH_FIRST_NUM: begin
          if (dig) begin
            pr_num = dec_accum(pr_num, c);
            pr_phase = (pr_prefix == KIND_V) ? PH_VNUM : PH_NUM;
          end else pr_err = 1'b1;
        end
        PH_NUM: begin
          if (dig) pr_num = dec_accum(pr_num, c);
          else pr_err = 1'b1;
        end
        PH_VNUM: begin
          if (dig) pr_num = dec_accum(pr_num, c);
          else if (c == CH_DOT) pr_phase = PH_ARR;
          else pr_err = 1'b1;
        end
        PH_ARR: begin
          if (c == CH_FOUR) pr_phase = PH_ARR_S;
          else if (c == CH_TWO) pr_phase = PH_ARR_D;
          else pr_err = 1'b1;
        end
        PH_ARR_S: begin
          if (c == CH_S) begin
            pr_wide = 1'b0;
            pr_phase = PH_OPEN;
          end else pr_err = 1'b1;
        end
        PH_ARR_D: begin
          if (c == CH_D) begin
            pr_wide = 1'b1;
            pr_phase = PH_OPEN;
          end else pr_err = 1'b1;
        end
        PH_OPEN: begin
          if (c == CH_OPEN) pr_phase = PH_LANE1;
          else pr_err = 1'b1;
        end
        PH_LANE1: begin
          if (dig) begin
            pr_lane = dec_accum(pr_lane, c);
            pr_phase = PH_LANE;
          end else pr_err = 1'b1;
        end
        PH_LANE: begin
          if (dig) pr_lane = dec_accum(pr_lane, c);
          else if (c == CH_CLOSE) pr_phase = PH_DONE;
          else pr_err = 1'b1;
        end
        PH_DONE: ;  // anything after the bracket is dropped
        default: pr_err = 1'b1;
      endcase
    end
    if (!last) return 1'b0;

    if (!pr_err) begin
      if (pr_phase == PH_NUM) begin
        if (pr_prefix == KIND_W && pr_num <= W_MAX)
          verdict = '{KIND_W, pr_num[4:0], 2'd0};
        else if ((pr_prefix == KIND_S || pr_prefix == KIND_D) && pr_num <= REG_MAX)
          verdict = '{pr_prefix, pr_num[4:0], 2'd0};
      end else if (pr_phase == PH_DONE && pr_num <= REG_MAX) begin
        if (!pr_wide && pr_lane <= LANE4S_MAX)
          verdict = '{KIND_V4S, pr_num[4:0], pr_lane[1:0]};
        else if (pr_wide && pr_lane <= LANE2D_MAX)
          verdict = '{KIND_V2D, pr_num[4:0], pr_lane[1:0]};
      end
    end
    pr_phase  = PH_START;
    pr_prefix = KIND_NONE;
    pr_num    = '0;
    pr_lane   = '0;
    pr_wide   = 1'b0;
    pr_err    = 1'b0;
    return 1'b1;
  endfunction

  // Mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || stall_hold || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Decimal text, usually near the legal range, sometimes huge, sometimes zero-padded
  function automatic string rand_number(input int common_max);
    string s;
    if ($urandom_range(0, 4) == 0) s = $sformatf("%0d", $urandom_range(0, 9999));
    else s = $sformatf("%0d", $urandom_range(0, common_max));
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) s = {"0", s};
    return s;
  endfunction

  function automatic void load_text(input string s);
    name_chars.delete();
    for (int k = 0; k < s.len(); k++) name_chars.push_back(s[k]);
  endfunction

  // Mostly well-formed names with random content; the rest are noise,
  // truncated names or names with one character replaced
  task automatic build_random_name();
    string text;
    string arr;
    int pick;
    int cut;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      name_chars.delete();
      repeat ($urandom_range(1, 6)) name_chars.push_back(8'($urandom_range(0, 255)));
      return;
    end
    case ($urandom_range(0, 3))
      0: text = {"w", rand_number(33)};
      1: text = {"s", rand_number(33)};
      2: text = {"d", rand_number(33)};
      default: begin
        cut = $urandom_range(0, 9);
        arr = (cut < 5) ? "4s" : (cut < 9) ? "2d" : "4d";
        text = {"v", rand_number(33), ".", arr, "[", rand_number(4), "]"};
        if ($urandom_range(0, 7) == 0) text = {text, "]x9"};
      end
    endcase
    load_text(text);
    if (pick < 18) begin
      cut = $urandom_range(1, name_chars.size() - 1);
      while (name_chars.size() > cut) void'(name_chars.pop_back());
    end else if (pick < 26) begin
      name_chars[$urandom_range(0, name_chars.size() - 1)] = 8'($urandom_range(0, 255));
    end
  endtask

  // Offer each character of name_chars, the final one flagged last
  task automatic send_name(input bit known, input parse_result_t want);
    parse_result_t verdict;
    bit done;
    int gap;
    for (int i = 0; i < name_chars.size(); i++) begin
      gap = pick_gap();
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= name_chars[i];
      s_axis_tlast  <= (i == name_chars.size() - 1);
      do @(posedge clk); while (!s_axis_tready);
      done = predict_name_char(name_chars[i], i == name_chars.size() - 1, verdict);
      if (done) pending_verdicts.push_back(known ? want : verdict);
      chars_sent++;
    end
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    mismatches++;
  endtask

  // Result checker
  always @(posedge clk) begin
    parse_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected result tdata", int'(m_axis_tdata), 0);
      end else begin
        want = pending_verdicts.pop_front();
        if (m_axis_tdata[2:0] != want.kind_code)
          report_mismatch("kind_code", int'(m_axis_tdata[2:0]), int'(want.kind_code));
        if (m_axis_tdata[7:3] != want.reg_number)
          report_mismatch("reg_number", int'(m_axis_tdata[7:3]), int'(want.reg_number));
        if (m_axis_tdata[9:8] != want.lane_number)
          report_mismatch("lane_number", int'(m_axis_tdata[9:8]), int'(want.lane_number));
        if (m_axis_tdata[TDATA_OUT_W-1:10] != '0)
          report_mismatch("tdata padding", int'(m_axis_tdata[TDATA_OUT_W-1:10]), 0);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int idle_left;
    idle_left = 0;
    forever begin
      @(posedge clk);
      if (stall_hold) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        stall_hold = 1'b0;
      end else if (idle_left > 0) begin
        m_axis_tready <= 1'b0;
        idle_left--;
      end else begin
        m_axis_tready <= 1'b1;
        idle_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
    end
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus: reset, directed names, then random names
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (name_rows[r]) begin
      if (name_rows[r].raw >= 0) begin
        name_chars.delete();
        name_chars.push_back(8'(name_rows[r].raw));
      end else begin
        load_text(name_rows[r].text);
      end
      send_name(name_rows[r].known, name_rows[r].want);
    end

    chars_sent = 0;
    while (chars_sent < RANDOM_ITEMS) begin
      if (!hold_done && chars_sent > 300) begin
        stall_hold = 1'b1;
        hold_done = 1'b1;
      end
      if ($urandom_range(0, 19) == 0) quiet = !quiet;
      build_random_name();
      send_name(1'b0, '{KIND_NONE, 5'd0, 2'd0});
    end
    s_axis_tvalid <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
